// ----- hw/rtl/hscp_pkg.sv -----
package hscp_pkg;

  localparam int unsigned StatusDigits = 3;
  localparam int unsigned PrefixLen    = 9;
  localparam logic [7:0]  Wildcard     = 8'h2a;
  localparam logic [7:0]  DigitZero    = 8'h30;

  typedef enum logic [1:0] {
    PhMatch  = 2'b01,
    PhDigits = 2'b10
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  match_pos;
    logic [1:0]  digits_seen;
    logic [15:0] code_sum;
  } state_t;

  localparam state_t StateReset = '{
    phase:       PhMatch,
    match_pos:   4'd0,
    digits_seen: 2'd0,
    code_sum:    16'd0
  };

  typedef struct packed {
    logic        emit;
    logic        status;
    logic [15:0] code;
  } result_t;

  // "HTTP/*.* "
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2f;
      4'd5:    c = Wildcard;
      4'd6:    c = 8'h2e;
      4'd7:    c = Wildcard;
      4'd8:    c = 8'h20;
      default: c = 8'h48;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/http_status_code_parser.sv -----
// HTTP status line code parser.
// Input channel: in_valid_i / in_stall_o carries one request per item, either a
// received byte (in_kind_i = 0, in_data_byte_i) or a link disconnect (in_kind_i = 1).
// Output channel: out_valid_o / out_stall_i carries a result: out_status_o = 0 with
// the three-digit code in out_code_o, or out_status_o = 1 (code 0) on disconnect.
// Bytes matching the "HTTP/x.y " prefix and the first digits produce no result.
// Flow: a request accepted into the input register is parsed there and, when it
// advances, its result is written into the result register.
// Throughput: one request per cycle unless the input stalls; the parse step (prefix
// compare or a multiply-by-ten and add) is combinational between the two registers.
// When the receiver stalls, the result register holds; a byte that causes no
// result still moves through, and the input side stalls only when a new result
// finds the result register full and stalled.
// Reset clears the parser state and empties both registers.
module http_status_code_parser #(
  parameter int unsigned StatusDigits = hscp_pkg::StatusDigits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_kind_i,
  input  logic [7:0]         in_data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_status_o,
  output logic signed [15:0] out_code_o
);

  logic              in_valid_q, in_valid_d;
  logic              kind_q;
  logic [7:0]        byte_q;
  hscp_pkg::state_t  state_q, state_d;
  hscp_pkg::result_t res;
  logic              out_valid_q, out_valid_d;
  logic              status_q;
  logic [15:0]       code_q;
  logic              accept;
  logic              advance;

  hscp_step #(
    .StatusDigits(StatusDigits)
  ) u_step (
    .state_i    (state_q),
    .kind_i     (kind_q),
    .data_byte_i(byte_q),
    .state_o    (state_d),
    .result_o   (res)
  );

  assign advance    = in_valid_q && (!res.emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= hscp_pkg::StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_kind_i;
      byte_q <= in_data_byte_i;
    end
    if (advance && res.emit) begin
      status_q <= res.status;
      code_q   <= res.code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_code_o   = code_q;

`ifndef SYNTH
  a_disc_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o |-> out_code_o == 16'sd0)
    else $error("disconnect result with nonzero code");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.match_pos < 4'(hscp_pkg::PrefixLen))
    else $error("match position out of range");

  a_digits_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == hscp_pkg::PhMatch |-> state_q.digits_seen == 2'd0
      && state_q.code_sum == 16'd0)
    else $error("digit state set while matching prefix");

  a_disc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && kind_q |=> state_q == hscp_pkg::StateReset)
    else $error("disconnect did not clear state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(advance && res.emit))
    else $error("result register overwritten while stalled");
`endif

endmodule

// ----- hw/rtl/hscp_step.sv -----
module hscp_step #(
  parameter int unsigned StatusDigits = hscp_pkg::StatusDigits
) (
  input  hscp_pkg::state_t  state_i,
  input  logic              kind_i,
  input  logic [7:0]        data_byte_i,
  output hscp_pkg::state_t  state_o,
  output hscp_pkg::result_t result_o
);

  logic [3:0]  pos;
  logic [3:0]  pos_inc;
  logic [7:0]  pat;
  logic        hit;
  logic [15:0] sum;
  logic [1:0]  dig_inc;
  logic        done;

  always_comb begin
    pos = (state_i.match_pos >= 4'(hscp_pkg::PrefixLen)) ? 4'd0 : state_i.match_pos;
    pos_inc = pos + 4'd1;
    pat = hscp_pkg::prefix_char(pos);
    hit = (pat == hscp_pkg::Wildcard) || (data_byte_i == pat);
    // code * 10 + signed byte - '0', wraps at 16 bits
    sum = (state_i.code_sum << 3) + (state_i.code_sum << 1)
        + {{8{data_byte_i[7]}}, data_byte_i} - {8'd0, hscp_pkg::DigitZero};
    dig_inc = state_i.digits_seen + 2'd1;
    done = (dig_inc >= 2'(StatusDigits)) || (dig_inc == 2'd0);
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{emit: 1'b0, status: 1'b0, code: 16'd0};
    if (kind_i) begin
      state_o  = hscp_pkg::StateReset;
      result_o = '{emit: 1'b1, status: 1'b1, code: 16'd0};
    end else if (state_i.phase == hscp_pkg::PhMatch) begin
      if (!hit) begin
        state_o.match_pos = 4'd0;
      end else if (pos_inc >= 4'(hscp_pkg::PrefixLen)) begin
        state_o = '{phase: hscp_pkg::PhDigits, match_pos: 4'd0,
                    digits_seen: 2'd0, code_sum: 16'd0};
      end else begin
        state_o.match_pos = pos_inc;
      end
    end else begin
      if (done) begin
        state_o  = hscp_pkg::StateReset;
        result_o = '{emit: 1'b1, status: 1'b0, code: sum};
      end else begin
        state_o.digits_seen = dig_inc;
        state_o.code_sum    = sum;
      end
    end
  end

endmodule
